// ===== src/prpm_pkg.sv =====
// prpm_pkg: shared types and constants of the pump rotation period monitor
// used by prpm_cfg, prpm_div and pump_rotation_period_monitor_core; no dependencies
package prpm_pkg;

	// register map, word index into the configuration space
	localparam logic [1:0] REG_UPPER_LIMIT     = 2'd0;
	localparam logic [1:0] REG_LOWER_LIMIT     = 2'd1;
	localparam logic [1:0] REG_BOLUS_ROTATIONS = 2'd2;
	localparam logic [1:0] REG_EXPECTED_PERIOD = 2'd3;

	// fixed limits of the period checks and the frequency report
	localparam logic [15:0] MIN_PERIOD     = 16'd200;
	localparam logic [16:0] LOWER_MARGIN   = 17'd500;
	localparam logic [15:0] PER_MIN_NUM    = 16'd60000;
	localparam logic [9:0]  PER_MIN_MAX    = 10'd1023;
	localparam logic [2:0]  SELFTEST_EVERY = 3'd4;
	localparam logic [15:0] ROT_MAX        = 16'hFFFF;

	typedef enum logic [2:0] {
		OP_TICK     = 3'd0,
		OP_START    = 3'd1,
		OP_BOLUS    = 3'd2,
		OP_SELFTEST = 3'd3,
		OP_STOP     = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		MODE_IDLE     = 2'd0,
		MODE_STARTED  = 2'd1,
		MODE_BOLUS    = 2'd2,
		MODE_SELFTEST = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ALARM_NONE     = 2'd0,
		ALARM_UNDERRUN = 2'd1,
		ALARM_OVERRUN  = 2'd2
	} alarm_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_EXEC = 2'd1,
		ST_DIV  = 2'd2,
		ST_OUT  = 2'd3
	} state_t;

	typedef struct packed {
		logic [15:0] upper_limit;
		logic [15:0] lower_limit;
		logic [15:0] bolus_rotations;
		logic [15:0] expected_period;
	} cfg_t;

	// divider request and response
	typedef struct packed {
		logic        start;
		logic [15:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [15:0] quotient;
	} div_rsp_t;

endpackage

// ===== src/pump_rotation_period_monitor_core.sv =====
// pump rotation period monitor: one transaction in, one transaction out
// sequence: idle accepts the input and execute updates the state; when a falling edge updates
// the period, 16 steps of the serial divider follow and the quotient is taken, then
// the output state presents the result transaction
// throughput: one item at a time; a new input is taken only after the result is accepted
// reset: asynchronous active-low arst_n clears the sequencer and architectural state, registers to defaults
module pump_rotation_period_monitor_core #(
	parameter int TICK_SCALE = 100,
	parameter int MISS_LIMIT = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	// stream input
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] marker, [7:1] zero
	input  logic [2:0]  s_tuser,   // [2:0] operation
	// stream output
	output logic        m_tvalid,
	input  logic        m_tready,
	// [1:0] alarm, [2] bolus_done, [4:3] mode_now, [20:5] period,
	// [30:21] per_minute, [46:31] selftest_period, [63:47] deviation
	output logic [63:0] m_tdata,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import prpm_pkg::*;

	localparam int TICK_CAP_I = ((65535 / TICK_SCALE) < 1023) ? (65535 / TICK_SCALE) : 1023;
	localparam logic [9:0] TICK_CAP = 10'(TICK_CAP_I);
	localparam logic [9:0] SCALE    = 10'(TICK_SCALE);
	localparam logic [2:0] MISS_LIM = 3'(MISS_LIMIT);

	cfg_t     cfg;
	div_req_t div_req;
	div_rsp_t div_rsp;

	state_t state_q, state_n;

	// captured input transaction
	logic [2:0] op_q;
	logic       marker_q;

	// architectural state
	mode_t       mode_q, mode_n;
	logic [9:0]  fall_q, fall_n;
	logic [9:0]  low_q, low_n;
	logic        last_q, last_n;
	logic        armed_q, armed_n;
	logic [15:0] rot_q, rot_n;
	logic [2:0]  stc_q, stc_n;
	logic [2:0]  miss_q, miss_n;
	logic [15:0] period_q, period_n;
	logic [9:0]  permin_q;
	logic [15:0] selftest_q, selftest_n;
	alarm_t      alarm_q, alarm_n;
	logic        bdone_q, bdone_n;
	logic        div_go;

	// tick datapath
	logic [9:0]  fall_inc, low_inc;
	logic [19:0] low_prod, fall_prod;
	logic [15:0] p_rise;
	logic [16:0] p_margin;
	logic        fell;

	assign pready = 1'b1;

	prpm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	prpm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// saturating tick counters and period products
	assign fall_inc  = (fall_q < TICK_CAP) ? fall_q + 10'd1 : TICK_CAP;
	assign low_inc   = (low_q < TICK_CAP) ? low_q + 10'd1 : TICK_CAP;
	assign low_prod  = 20'(low_inc) * 20'(SCALE);
	assign fall_prod = 20'(fall_inc) * 20'(SCALE);
	assign p_rise    = low_prod[15:0];
	assign p_margin  = {1'b0, p_rise} + LOWER_MARGIN;
	assign fell      = !marker_q && last_q;

	// next architectural state for the captured transaction
	always_comb begin
		mode_n     = mode_q;
		fall_n     = fall_q;
		low_n      = low_q;
		last_n     = last_q;
		armed_n    = armed_q;
		rot_n      = rot_q;
		stc_n      = stc_q;
		miss_n     = miss_q;
		period_n   = period_q;
		selftest_n = selftest_q;
		alarm_n    = ALARM_NONE;
		bdone_n    = 1'b0;
		div_go     = 1'b0;
		case (op_q)
			OP_TICK: begin
				if (mode_q == MODE_IDLE) begin
					miss_n = 3'd0;
				end else begin
					fall_n = fall_inc;
					low_n  = low_inc;
					// rise-to-rise check in started mode
					if (marker_q) begin
						if (!last_q && mode_q == MODE_STARTED) begin
							if (p_rise < MIN_PERIOD || p_rise > cfg.upper_limit) begin
								if (miss_q >= MISS_LIM) begin
									miss_n  = 3'd0;
									alarm_n = ALARM_UNDERRUN;
								end else begin
									miss_n = miss_q + 3'd1;
								end
							end else if (p_margin < {1'b0, cfg.lower_limit}) begin
								if (miss_q >= MISS_LIM) begin
									miss_n  = 3'd0;
									alarm_n = ALARM_OVERRUN;
								end else begin
									miss_n = miss_q + 3'd1;
								end
							end else begin
								miss_n = 3'd0;
							end
						end
						low_n = 10'd0;
					end
					// fall-to-fall rotation
					if (fell) begin
						if (!armed_q) begin
							armed_n = 1'b1;
							fall_n  = 10'd0;
						end else begin
							rot_n    = (rot_q != ROT_MAX) ? rot_q + 16'd1 : ROT_MAX;
							period_n = fall_prod[15:0];
							if (mode_q == MODE_BOLUS && rot_n >= cfg.bolus_rotations) begin
								bdone_n = 1'b1;
								mode_n  = MODE_IDLE;
								rot_n   = 16'd0;
								stc_n   = 3'd0;
							end
							if (mode_q == MODE_SELFTEST) begin
								stc_n = stc_q + 3'd1;
								if (stc_n >= SELFTEST_EVERY) begin
									selftest_n = period_n;
									stc_n      = 3'd0;
								end
							end
							div_go = 1'b1;
							fall_n = 10'd0;
						end
					end
					last_n = marker_q;
				end
			end
			OP_START: begin
				mode_n = MODE_STARTED;
				rot_n  = 16'd0;
			end
			OP_BOLUS: begin
				mode_n = MODE_BOLUS;
				rot_n  = 16'd0;
			end
			OP_SELFTEST: begin
				mode_n     = MODE_SELFTEST;
				selftest_n = 16'd0;
				fall_n     = 10'd0;
			end
			OP_STOP: begin
				mode_n = MODE_IDLE;
			end
			default: ;
		endcase
	end

	// sequencer next state and handshake outputs
	always_comb begin
		state_n         = state_q;
		s_tready        = 1'b0;
		m_tvalid        = 1'b0;
		div_req.start   = 1'b0;
		div_req.divisor = period_n;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) state_n = ST_EXEC;
			end
			ST_EXEC: begin
				div_req.start = div_go;
				state_n = div_go ? ST_DIV : ST_OUT;
			end
			ST_DIV: begin
				if (div_rsp.done) state_n = ST_OUT;
			end
			ST_OUT: begin
				m_tvalid = 1'b1;
				if (m_tready) state_n = ST_IDLE;
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_n;
	end

	// input capture
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_q     <= s_tuser;
			marker_q <= s_tdata[0];
		end
	end

	// architectural state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_IDLE;
			fall_q     <= 10'd0;
			low_q      <= 10'd0;
			last_q     <= 1'b1;
			armed_q    <= 1'b0;
			rot_q      <= 16'd0;
			stc_q      <= 3'd0;
			miss_q     <= 3'd0;
			period_q   <= 16'd0;
			permin_q   <= 10'd0;
			selftest_q <= 16'd0;
			alarm_q    <= ALARM_NONE;
			bdone_q    <= 1'b0;
		end else begin
			if (state_q == ST_EXEC) begin
				mode_q     <= mode_n;
				fall_q     <= fall_n;
				low_q      <= low_n;
				last_q     <= last_n;
				armed_q    <= armed_n;
				rot_q      <= rot_n;
				stc_q      <= stc_n;
				miss_q     <= miss_n;
				period_q   <= period_n;
				selftest_q <= selftest_n;
				alarm_q    <= alarm_n;
				bdone_q    <= bdone_n;
			end
			// saturated frequency from the divider
			if (state_q == ST_DIV && div_rsp.done) begin
				permin_q <= (div_rsp.quotient > 16'(PER_MIN_MAX)) ? PER_MIN_MAX
				                                                : div_rsp.quotient[9:0];
			end
		end
	end

	// result transaction
	assign m_tdata = {
		{1'b0, period_q} - {1'b0, cfg.expected_period},
		selftest_q,
		permin_q,
		period_q,
		mode_q,
		bdone_q,
		alarm_q
	};

`ifndef ASSERT_OFF
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input and output handshakes open together");

	a_bolus_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && bdone_q) |-> (mode_q == MODE_IDLE))
		else $error("bolus end without return to idle");

	a_miss_bound: assert property (@(posedge clk) disable iff (!arst_n)
		miss_q <= MISS_LIM)
		else $error("miss count above limit");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_DIV))
		else $error("divider finished outside the divide state");
`endif

endmodule

// ===== src/prpm_cfg.sv =====
// prpm_cfg: configuration register file behind the register bus port
// depends on prpm_pkg for the register map and cfg_t
module prpm_cfg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output prpm_pkg::cfg_t     cfg
);
	import prpm_pkg::*;

	cfg_t cfg_q;
	logic wr_en;

	assign wr_en = psel && penable && pwrite;

	// register write on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.upper_limit     <= 16'hFFFF;
			cfg_q.lower_limit     <= 16'd0;
			cfg_q.bolus_rotations <= 16'd100;
			cfg_q.expected_period <= 16'd0;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_UPPER_LIMIT:     cfg_q.upper_limit     <= pwdata[15:0];
				REG_LOWER_LIMIT:     cfg_q.lower_limit     <= pwdata[15:0];
				REG_BOLUS_ROTATIONS: cfg_q.bolus_rotations <= pwdata[15:0];
				REG_EXPECTED_PERIOD: cfg_q.expected_period <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (paddr[3:2])
			REG_UPPER_LIMIT:     prdata = {16'd0, cfg_q.upper_limit};
			REG_LOWER_LIMIT:     prdata = {16'd0, cfg_q.lower_limit};
			REG_BOLUS_ROTATIONS: prdata = {16'd0, cfg_q.bolus_rotations};
			REG_EXPECTED_PERIOD: prdata = {16'd0, cfg_q.expected_period};
			default:             prdata = 32'd0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// ===== src/prpm_div.sv =====
// prpm_div: radix-2 restoring divider, 60000 over a 16-bit divisor, one bit per cycle
// depends on prpm_pkg for the request and response structs
module prpm_div (
	input  logic                clk,
	input  logic                arst_n,
	input  prpm_pkg::div_req_t  req,
	output prpm_pkg::div_rsp_t  rsp
);
	import prpm_pkg::*;

	logic        busy_q;
	logic        done_q;
	logic [3:0]  cnt_q;
	logic [15:0] rem_q;
	logic [15:0] quo_q;
	logic [15:0] div_q;

	logic [16:0] shifted;
	logic        fits;
	logic [16:0] diff;

	// one trial subtraction per cycle
	assign shifted = {rem_q, quo_q[15]};
	assign fits    = shifted >= {1'b0, div_q};
	assign diff    = shifted - {1'b0, div_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 4'd0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 4'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'hF) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: remainder, quotient shifting in, divisor
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= 16'd0;
			quo_q <= PER_MIN_NUM;
			div_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[15:0] : shifted[15:0];
			quo_q <= {quo_q[14:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule
